>>> src/npim_pkg.sv
// shared types and constants for the nearest palette index mapper
`timescale 1ns / 1ps

package npim_pkg;

  // field widths fixed by the interface
  localparam int unsigned CHAN_W = 8;
  localparam int unsigned IDX_W  = 8;
  localparam int unsigned CFG_W  = 9;
  localparam int unsigned RGB_W  = 3 * CHAN_W;
  localparam int unsigned SQ_W   = 2 * CHAN_W;
  localparam int unsigned DIST_W = SQ_W + 2;

  // request function codes
  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_PIXEL = 1'b1;

  // configuration register indexes
  localparam logic CFG_ALPHA_THR = 1'b0;
  localparam logic CFG_COLORS    = 1'b1;

  // configuration reset values
  localparam logic [CFG_W-1:0] ALPHA_THR_RST = 9'd64;
  localparam logic [CFG_W-1:0] COLORS_RST    = 9'd256;

  // controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_DRAIN,
    S_DONE
  } state_e;

  // tag that travels with each palette read through the distance pipeline
  typedef struct packed {
    logic             vld;
    logic             first;
    logic             last;
    logic [IDX_W-1:0] idx;
  } rd_tag_t;

endpackage

>>> src/npim_ram.sv
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps

module npim_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/npim_dist.sv
// two-stage squared rgb distance pipeline
`timescale 1ns / 1ps

module npim_dist (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  npim_pkg::rd_tag_t             tag_i,
  input  logic [npim_pkg::RGB_W-1:0]    entry_i,
  input  logic [npim_pkg::CHAN_W-1:0]   red_i,
  input  logic [npim_pkg::CHAN_W-1:0]   green_i,
  input  logic [npim_pkg::CHAN_W-1:0]   blue_i,
  output npim_pkg::rd_tag_t             tag_o,
  output logic [npim_pkg::DIST_W-1:0]   dist_o
);

  logic [npim_pkg::CHAN_W-1:0] ent_r, ent_g, ent_b;
  logic [npim_pkg::CHAN_W-1:0] dr, dg, db;
  logic [npim_pkg::SQ_W-1:0]   sq_r_q, sq_g_q, sq_b_q;
  logic [npim_pkg::DIST_W-1:0] dist_q;
  npim_pkg::rd_tag_t           tag1_q, tag2_q;

  // split entry and take absolute differences
  assign ent_r = entry_i[3*npim_pkg::CHAN_W-1:2*npim_pkg::CHAN_W];
  assign ent_g = entry_i[2*npim_pkg::CHAN_W-1:npim_pkg::CHAN_W];
  assign ent_b = entry_i[npim_pkg::CHAN_W-1:0];
  assign dr = (ent_r > red_i)   ? (ent_r - red_i)   : (red_i - ent_r);
  assign dg = (ent_g > green_i) ? (ent_g - green_i) : (green_i - ent_g);
  assign db = (ent_b > blue_i)  ? (ent_b - blue_i)  : (blue_i - ent_b);

  // stage one: squares
  always_ff @(posedge clk_i) begin
    sq_r_q <= npim_pkg::SQ_W'(dr) * npim_pkg::SQ_W'(dr);
    sq_g_q <= npim_pkg::SQ_W'(dg) * npim_pkg::SQ_W'(dg);
    sq_b_q <= npim_pkg::SQ_W'(db) * npim_pkg::SQ_W'(db);
  end

  // stage two: sum of squares
  always_ff @(posedge clk_i) begin
    dist_q <= npim_pkg::DIST_W'(sq_r_q) + npim_pkg::DIST_W'(sq_g_q)
            + npim_pkg::DIST_W'(sq_b_q);
  end

  // tag pipeline, valid cleared at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag1_q <= '0;
      tag2_q <= '0;
    end else begin
      tag1_q <= tag_i;
      tag2_q <= tag1_q;
    end
  end

  assign tag_o  = tag2_q;
  assign dist_o = dist_q;

endmodule

>>> src/nearest_palette_index_mapper_top.sv
// top level: palette store, search sequencer and result register
`timescale 1ns / 1ps

// Maps pixels to palette indexes. A write request (func 0) loads one 24-bit
// palette entry. A pixel request (func 1) with alpha below alpha_threshold
// gives index 0 with is_transparent set, by way of the result state and the
// output register. Any other pixel is compared against entries 1 .. N-1
// (N = colors_in_use, clamped to 2 .. PALETTE_ENTRIES), one entry per cycle
// through the single read port of the palette ram, then a two-stage distance
// pipeline; the next request is taken once the result sits in the output
// register. Palette entries read as zero until written, so no clearing pass
// is needed after reset.
module nearest_palette_index_mapper_top #(
  parameter int unsigned PALETTE_ENTRIES = 256
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration
  input  logic                          cfg_we_i,
  input  logic                          cfg_index_i,
  input  logic [npim_pkg::CFG_W-1:0]    cfg_wdata_i,
  // request channel
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          func_i,
  input  logic [npim_pkg::IDX_W-1:0]    entry_index_i,
  input  logic [npim_pkg::CHAN_W-1:0]   alpha_i,
  input  logic [npim_pkg::CHAN_W-1:0]   red_i,
  input  logic [npim_pkg::CHAN_W-1:0]   green_i,
  input  logic [npim_pkg::CHAN_W-1:0]   blue_i,
  // result channel
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [npim_pkg::IDX_W-1:0]    pal_idx_o,
  output logic                          is_transparent_o
);

  localparam int unsigned AW = $clog2(PALETTE_ENTRIES);
  localparam logic [npim_pkg::CFG_W-1:0] NumEnt = npim_pkg::CFG_W'(PALETTE_ENTRIES);
  localparam logic [AW-1:0] LastEnt = AW'(PALETTE_ENTRIES - 1);

  // configuration registers
  logic [npim_pkg::CFG_W-1:0] alpha_thr_q, colors_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_thr_q <= npim_pkg::ALPHA_THR_RST;
      colors_q    <= npim_pkg::COLORS_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        npim_pkg::CFG_ALPHA_THR: alpha_thr_q <= cfg_wdata_i;
        npim_pkg::CFG_COLORS:    colors_q    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // request decode
  npim_pkg::state_e state_q, state_d;
  logic req_acc, wr_acc, pix_acc, pix_transp;
  logic wr_in_range;

  assign req_acc     = in_valid_i && in_ready_o;
  assign wr_acc      = req_acc && (func_i == npim_pkg::FUNC_WRITE);
  assign pix_acc     = req_acc && (func_i == npim_pkg::FUNC_PIXEL);
  assign pix_transp  = ({1'b0, alpha_i} < alpha_thr_q);
  assign wr_in_range = ({1'b0, entry_index_i} < NumEnt);

  // last searched entry from the clamped colour count
  logic [AW-1:0] last_idx;
  always_comb begin
    priority if (colors_q < 9'd2) begin
      last_idx = AW'(1);
    end else if (colors_q > NumEnt) begin
      last_idx = LastEnt;
    end else begin
      last_idx = AW'(colors_q - 9'd1);
    end
  end

  // per-request registers
  logic [npim_pkg::CHAN_W-1:0] pix_r_q, pix_g_q, pix_b_q;
  logic [AW-1:0]               last_q;
  logic [AW-1:0]               rd_idx_q, rd_idx_d;

  always_ff @(posedge clk_i) begin
    if (pix_acc) begin
      pix_r_q <= red_i;
      pix_g_q <= green_i;
      pix_b_q <= blue_i;
      last_q  <= last_idx;
    end
  end

  // entry valid bits: unwritten entries read as zero
  logic [PALETTE_ENTRIES-1:0] ent_vld_q;
  logic                       ent_vld_rd_q;
  logic                       ram_we;

  assign ram_we = wr_acc && wr_in_range;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_vld_q <= '0;
    end else if (ram_we) begin
      ent_vld_q[entry_index_i[AW-1:0]] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_vld_rd_q <= ent_vld_q[rd_idx_q];
  end

  // palette store
  logic [npim_pkg::RGB_W-1:0] ram_rdata, entry;

  npim_ram #(
    .WIDTH (npim_pkg::RGB_W),
    .DEPTH (PALETTE_ENTRIES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (entry_index_i[AW-1:0]),
    .wdata_i ({red_i, green_i, blue_i}),
    .raddr_i (rd_idx_q),
    .rdata_o (ram_rdata)
  );

  assign entry = ent_vld_rd_q ? ram_rdata : '0;

  // sequencer outputs
  logic    issue, load_out;
  npim_pkg::rd_tag_t rd_tag_d, rd_tag_q;

  // next state
  npim_pkg::rd_tag_t dist_tag;
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      npim_pkg::S_IDLE: begin
        if (pix_acc) begin
          state_d = pix_transp ? npim_pkg::S_DONE : npim_pkg::S_SEARCH;
        end
      end
      npim_pkg::S_SEARCH: begin
        if (rd_idx_q == last_q) begin
          state_d = npim_pkg::S_DRAIN;
        end
      end
      npim_pkg::S_DRAIN: begin
        if (dist_tag.vld && dist_tag.last) begin
          state_d = npim_pkg::S_DONE;
        end
      end
      npim_pkg::S_DONE: begin
        if (!out_valid_o || out_ready_i) begin
          state_d = npim_pkg::S_IDLE;
        end
      end
      default: state_d = npim_pkg::S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready_o = 1'b0;
    issue      = 1'b0;
    load_out   = 1'b0;
    rd_idx_d   = rd_idx_q;
    unique case (state_q)
      npim_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (pix_acc) begin
          rd_idx_d = AW'(1);
        end
      end
      npim_pkg::S_SEARCH: begin
        issue    = 1'b1;
        rd_idx_d = rd_idx_q + AW'(1);
      end
      npim_pkg::S_DRAIN: ;
      npim_pkg::S_DONE: begin
        load_out = !out_valid_o || out_ready_i;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= npim_pkg::S_IDLE;
      rd_idx_q <= '0;
    end else begin
      state_q  <= state_d;
      rd_idx_q <= rd_idx_d;
    end
  end

  // tag aligned with the registered ram read
  always_comb begin
    rd_tag_d.vld   = issue;
    rd_tag_d.first = (rd_idx_q == AW'(1));
    rd_tag_d.last  = (rd_idx_q == last_q);
    rd_tag_d.idx   = npim_pkg::IDX_W'(rd_idx_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_tag_q <= '0;
    end else begin
      rd_tag_q <= rd_tag_d;
    end
  end

  // distance pipeline
  logic [npim_pkg::DIST_W-1:0] ent_dist;

  npim_dist u_dist (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .tag_i   (rd_tag_q),
    .entry_i (entry),
    .red_i   (pix_r_q),
    .green_i (pix_g_q),
    .blue_i  (pix_b_q),
    .tag_o   (dist_tag),
    .dist_o  (ent_dist)
  );

  // running minimum, lowest index wins on a tie
  logic [npim_pkg::DIST_W-1:0] best_dist_q;
  logic [npim_pkg::IDX_W-1:0]  best_idx_q;
  logic                        transp_q;

  always_ff @(posedge clk_i) begin
    if (pix_acc) begin
      best_idx_q <= '0;
      transp_q   <= pix_transp;
    end else if (dist_tag.vld && (dist_tag.first || (ent_dist < best_dist_q))) begin
      best_idx_q  <= dist_tag.idx;
      best_dist_q <= ent_dist;
    end
  end

  // result register
  logic                       out_valid_q;
  logic [npim_pkg::IDX_W-1:0] out_idx_q;
  logic                       out_transp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_idx_q    <= best_idx_q;
      out_transp_q <= transp_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign pal_idx_o        = out_idx_q;
  assign is_transparent_o = out_transp_q;

  // a transparent result always carries index zero
  a_transp_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && is_transparent_o) |-> (pal_idx_o == '0))
    else $error("transparent result with nonzero index");

  // an opaque result points into the palette range, excluding entry zero
  a_opaque_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !is_transparent_o) |->
      ((pal_idx_o != '0) && ({1'b0, pal_idx_o} < NumEnt)))
    else $error("opaque result outside palette range");

  // the last distance closes the search
  a_last_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dist_tag.vld && dist_tag.last) |=> (state_q == npim_pkg::S_DONE))
    else $error("search end not followed by result stage");

  // the distance pipeline is empty when the result is handed over
  a_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == npim_pkg::S_DONE) |-> (!dist_tag.vld && !rd_tag_q.vld))
    else $error("distance pipeline busy in result stage");

endmodule
